// ----- rtl/core/rsti_pkg.sv -----
`default_nettype none

package rsti_pkg;

  // ASCII codes used by the character classifier
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;

  // radix register
  localparam int unsigned RADIX_W     = 5;
  localparam logic [4:0]  RADIX_RESET = 5'd10;
  localparam logic [4:0]  RADIX_MIN   = 5'd2;
  localparam logic [4:0]  RADIX_MAX   = 5'd16;

  // digit value width; NO_DIGIT is above any legal radix
  localparam int unsigned DIGIT_W  = 5;
  localparam logic [4:0]  NO_DIGIT = 5'h1F;
  localparam logic [4:0]  TEN      = 5'd10;

  // decoupling queue depth
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CK_DIGIT,
    CK_MINUS,
    CK_BAD
  } char_kind_t;

  typedef struct packed {
    char_kind_t  kind;
    logic [3:0]  digit;
    logic        last;
  } char_item_t;

  // digit value of an ASCII character, NO_DIGIT if not a digit
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] d;
    d = NO_DIGIT;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d = 5'(c - CHAR_ZERO);
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
      d = 5'(c - CHAR_LOWER_A) + TEN;
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      d = 5'(c - CHAR_UPPER_A) + TEN;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rsti_front.sv -----
`default_nettype none

module rsti_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [4:0]            cfg_wr_data,
  input  wire logic [7:0]            char_code,
  input  wire logic                  end_of_string,
  output rsti_pkg::char_item_t       item,
  output logic [4:0]                 radix_eff
);

  logic [4:0] radix_r;
  logic [4:0] dig;

  // radix register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= rsti_pkg::RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix_r <= cfg_wr_data;
    end
  end

  // clamp radix to 2..16
  always_comb begin
    if (radix_r < rsti_pkg::RADIX_MIN) begin
      radix_eff = rsti_pkg::RADIX_MIN;
    end else if (radix_r > rsti_pkg::RADIX_MAX) begin
      radix_eff = rsti_pkg::RADIX_MAX;
    end else begin
      radix_eff = radix_r;
    end
  end

  // classify the character
  always_comb begin
    dig        = rsti_pkg::digit_of(char_code);
    item.last  = end_of_string;
    item.digit = dig[3:0];
    if (char_code == rsti_pkg::CHAR_MINUS) begin
      item.kind = rsti_pkg::CK_MINUS;
    end else if (dig < radix_eff) begin
      item.kind = rsti_pkg::CK_DIGIT;
    end else begin
      item.kind = rsti_pkg::CK_BAD;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rsti_queue.sv -----
`default_nettype none

module rsti_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire rsti_pkg::char_item_t  push_item,
  input  wire logic                  pop,
  output rsti_pkg::char_item_t       head,
  output logic                       not_empty,
  output logic                       full
);

  localparam int unsigned DEPTH = rsti_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  rsti_pkg::char_item_t slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == FULL_CNT);
  assign head      = slots_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("pointers differ while queue empty");

endmodule

`default_nettype wire

// ----- rtl/core/rsti_back.sv -----
`default_nettype none

module rsti_back #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire rsti_pkg::char_item_t    head,
  input  wire logic                    not_empty,
  input  wire logic [4:0]              radix_eff,
  output logic                         pop,
  output logic                         res_valid,
  input  wire logic                    res_stall,
  output logic [VALUE_WIDTH-1:0]       res_value,
  output logic                         res_bad,
  output logic                         res_ovf
);

  localparam int unsigned PROD_W = VALUE_WIDTH + rsti_pkg::RADIX_W;
  localparam logic [PROD_W-1:0] POS_LIMIT = PROD_W'({1'b0, {(VALUE_WIDTH-1){1'b1}}});

  // parse state
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic neg_r, neg_nxt;
  logic first_r, first_nxt;
  logic bad_r, bad_nxt;
  logic ovf_r, ovf_nxt;

  // result register
  logic                   out_valid_r, out_valid_nxt;
  logic [VALUE_WIDTH-1:0] out_mag_r;
  logic                   out_neg_r, out_bad_r, out_ovf_r;

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] limit;

  // a non-final item never waits for the result register
  assign pop = not_empty && (!head.last || !out_valid_r || !res_stall);

  // multiply-accumulate and range check
  always_comb begin
    prod  = PROD_W'(acc_r) * PROD_W'(radix_eff) + PROD_W'(head.digit);
    limit = POS_LIMIT + PROD_W'(neg_r);
  end

  // next parse state for the popped item
  always_comb begin
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    first_nxt = first_r;
    bad_nxt   = bad_r;
    ovf_nxt   = ovf_r;
    if (pop) begin
      first_nxt = 1'b0;
      if (!bad_r) begin
        unique case (head.kind)
          rsti_pkg::CK_MINUS: begin
            if (first_r) neg_nxt = 1'b1;
            else         bad_nxt = 1'b1;
          end
          rsti_pkg::CK_DIGIT: begin
            if (!ovf_r && prod > limit) ovf_nxt = 1'b1;
            acc_nxt = prod[VALUE_WIDTH-1:0];
          end
          default: bad_nxt = 1'b1;
        endcase
      end
    end
  end

  // parse state registers; end of string clears them
  always_ff @(posedge clk) begin
    if (!rst_n || (pop && head.last)) begin
      acc_r   <= '0;
      neg_r   <= 1'b0;
      first_r <= 1'b1;
      bad_r   <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      first_r <= first_nxt;
      bad_r   <= bad_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r && res_stall;
    if (pop && head.last) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      out_mag_r <= acc_nxt;
      out_neg_r <= neg_nxt;
      out_bad_r <= bad_nxt;
      out_ovf_r <= ovf_nxt;
    end
  end

  // apply sign, force zero after a bad digit
  always_comb begin
    if (out_bad_r) begin
      res_value = '0;
    end else if (out_neg_r) begin
      res_value = '0 - out_mag_r;
    end else begin
      res_value = out_mag_r;
    end
  end

  assign res_valid = out_valid_r;
  assign res_bad   = out_bad_r;
  assign res_ovf   = out_ovf_r;

  a_zero_on_bad: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |-> (res_value == '0))
    else $error("nonzero value with bad digit");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pop && head.last))
    else $error("result without end of string");

  a_first_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.last) |=> (first_r && !bad_r && !ovf_r))
    else $error("parse state not cleared after end of string");

endmodule

`default_nettype wire

// ----- rtl/core/radix_string_to_integer.sv -----
// Signed integer parser for ASCII strings in radix 2..16.
// Input channel: in_valid/in_stall carry one character per item
// (in_char_code) and in_end_of_string marking the last character.
// Output channel: out_valid/out_stall carry one result per string:
// out_value (two's complement, 0 after a bad digit), out_bad_digit and
// out_overflow. Characters that are not the last give no result.
// Configuration: cfg_wr_en writes cfg_wr_data into the radix register;
// values below 2 act as 2, above 16 as 16. Write only while idle.
// Throughput: one character per cycle while in_stall is low. The front classifies the
// character, a two-entry queue holds it, and the back does one
// multiply-by-radix and add per cycle.
// Result path: the last character is written into the queue, and the back
// pops it from the queue into the result register, which presents the result.
// Reset (rst_n, synchronous, active low): radix back to 10, queue
// emptied, parse state cleared, no result pending.
// Receiver stall: the result holds in its register; characters keep
// flowing until the next end-of-string item reaches the back, then the
// queue fills and in_stall rises.
`default_nettype none

module radix_string_to_integer #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_wr_en,
  input  wire logic [4:0]              cfg_wr_data,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [7:0]              in_char_code,
  input  wire logic                    in_end_of_string,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [VALUE_WIDTH-1:0] out_value,
  output logic                         out_bad_digit,
  output logic                         out_overflow
);

  rsti_pkg::char_item_t front_item;
  rsti_pkg::char_item_t q_head;
  logic [4:0] radix_eff;
  logic q_full, q_not_empty, q_push, q_pop;
  logic [VALUE_WIDTH-1:0] res_value;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  rsti_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .char_code    (in_char_code),
    .end_of_string(in_end_of_string),
    .item         (front_item),
    .radix_eff    (radix_eff)
  );

  rsti_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (front_item),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  rsti_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .not_empty (q_not_empty),
    .radix_eff (radix_eff),
    .pop       (q_pop),
    .res_valid (out_valid),
    .res_stall (out_stall),
    .res_value (res_value),
    .res_bad   (out_bad_digit),
    .res_ovf   (out_overflow)
  );

  assign out_value = $signed(res_value);

endmodule

`default_nettype wire

// ----- verif/tb_radix_string_to_integer.sv -----
`default_nettype none

module tb_radix_string_to_integer;

  localparam int ITEM_TARGET = 1150;
  // extra wait after the last expected result has been taken
  localparam int DRAIN_CYCLES = 6;

  typedef struct {
    logic signed [31:0] value;
    logic               bad_digit;
    logic               overflow;
  } parse_result_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [4:0]        cfg_wr_data;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_char_code;
  logic              in_end_of_string;
  logic              out_valid;
  logic              out_stall;
  logic signed [31:0] out_value;
  logic              out_bad_digit;
  logic              out_overflow;

  // expected parse results, oldest first
  parse_result_t expected_results[$];
  int            mismatch_count = 0;
  int            items_sent = 0;

  // idling control for the sender and the receiver
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int rx_long_hold = 0;

  // parser state as the block should hold it
  logic [4:0]        radix_shadow;
  longint unsigned   acc_shadow;
  logic              neg_shadow;
  logic              first_shadow;
  logic              bad_shadow;
  logic              ovf_shadow;

  radix_string_to_integer #(
    .VALUE_WIDTH(32)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_code    (in_char_code),
    .in_end_of_string(in_end_of_string),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_value       (out_value),
    .out_bad_digit   (out_bad_digit),
    .out_overflow    (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // number base actually used: clamped to 2..16
  function automatic int radix_used();
    if (radix_shadow < rsti_pkg::RADIX_MIN) return rsti_pkg::RADIX_MIN;
    if (radix_shadow > rsti_pkg::RADIX_MAX) return rsti_pkg::RADIX_MAX;
    return radix_shadow;
  endfunction

  // digit value of a character, 255 for anything else
  function automatic int char_digit(input logic [7:0] c);
    if (c >= rsti_pkg::CHAR_ZERO && c <= rsti_pkg::CHAR_NINE)
      return c - rsti_pkg::CHAR_ZERO;
    if (c >= rsti_pkg::CHAR_LOWER_A && c <= rsti_pkg::CHAR_LOWER_F)
      return c - rsti_pkg::CHAR_LOWER_A + 10;
    if (c >= rsti_pkg::CHAR_UPPER_A && c <= rsti_pkg::CHAR_UPPER_F)
      return c - rsti_pkg::CHAR_UPPER_A + 10;
    return 255;
  endfunction

  // ASCII for a digit value, letters in random case
  function automatic logic [7:0] digit_char(input int d);
    if (d < 10) return 8'(rsti_pkg::CHAR_ZERO + d);
    return 8'(($urandom_range(0, 1) ? rsti_pkg::CHAR_UPPER_A : rsti_pkg::CHAR_LOWER_A)
              + d - 10);
  endfunction

  function automatic void clear_parse_state();
    acc_shadow   = 0;
    neg_shadow   = 1'b0;
    first_shadow = 1'b1;
    bad_shadow   = 1'b0;
    ovf_shadow   = 1'b0;
  endfunction

  // advance the parser by one accepted character
  function automatic void parse_char(input logic [7:0] c, input logic eos);
    longint unsigned r, d, lim;
    logic            was_first;
    parse_result_t   res;
    was_first    = first_shadow;
    first_shadow = 1'b0;
    if (!bad_shadow) begin
      if (c == rsti_pkg::CHAR_MINUS) begin
        if (was_first) neg_shadow = 1'b1;
        else bad_shadow = 1'b1;
      end else begin
        r = radix_used();
        d = char_digit(c);
        if (d >= r) begin
          bad_shadow = 1'b1;
        end else begin
          // largest magnitude allowed for this sign
          if (!ovf_shadow) begin
            lim = 64'h7FFF_FFFF + (neg_shadow ? 1 : 0);
            if (acc_shadow > (lim - d) / r) ovf_shadow = 1'b1;
          end
          acc_shadow = (acc_shadow * r + d) & 64'hFFFF_FFFF;
        end
      end
    end
    if (eos) begin
      if (bad_shadow) res.value = '0;
      else if (neg_shadow) res.value = 32'(64'd0 - acc_shadow);
      else res.value = 32'(acc_shadow);
      res.bad_digit = bad_shadow;
      res.overflow  = ovf_shadow;
      expected_results.push_back(res);
      clear_parse_state();
    end
  endfunction

  // offer one character, wait until it is taken
  task automatic send_char(input logic [7:0] c, input logic eos);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid         = 1'b1;
    in_char_code     = c;
    in_end_of_string = eos;
    do @(posedge clk); while (in_stall);
    parse_char(c, eos);
    items_sent++;
  endtask

  task automatic send_text(input logic [7:0] text[$]);
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  // stop offering and let the pipeline empty
  task automatic wait_block_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_radix(input logic [4:0] v);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    radix_shadow = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // one random string: well-formed, a large value near or past the signed limits, or noise
  task automatic send_random_string();
    logic [7:0]      text[$];
    int              kind, len, r;
    longint unsigned mag;
    r    = radix_used();
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      if ($urandom_range(0, 3) == 0) text.push_back(rsti_pkg::CHAR_MINUS);
      len = $urandom_range(1, (r <= 4) ? 34 : 10);
      repeat (len) text.push_back(digit_char($urandom_range(0, r - 1)));
    end else if (kind < 75) begin
      case ($urandom_range(0, 4))
        0: mag = 64'h7FFF_FFFF;
        1: mag = 64'h8000_0000;
        2: mag = 64'h8000_0001;
        3: mag = longint'($urandom);
        default: mag = (longint'($urandom_range(0, 255)) << 32) | longint'($urandom);
      endcase
      if (mag == 0) text.push_back(digit_char(0));
      while (mag > 0) begin
        text.push_front(digit_char(int'(mag % r)));
        mag = mag / r;
      end
      if ($urandom_range(0, 4) == 0) text.push_front(digit_char(0));
      if ($urandom_range(0, 1)) text.push_front(rsti_pkg::CHAR_MINUS);
    end else begin
      // noise and broken strings
      len = $urandom_range(1, 6);
      repeat (len) begin
        case ($urandom_range(0, 3))
          0: text.push_back(8'($urandom_range(0, 255)));
          1: text.push_back(rsti_pkg::CHAR_MINUS);
          default: text.push_back(digit_char($urandom_range(0, 15)));
        endcase
      end
    end
    send_text(text);
  endtask

  // sign handling and bad characters at the reset radix
  task automatic test_sign_and_bad_chars();
    send_text('{rsti_pkg::CHAR_MINUS});
    send_text('{8'h37});
    send_text('{8'h31, rsti_pkg::CHAR_MINUS});
    send_text('{8'h00, 8'h39});
    send_text('{8'hFF});
  endtask

  // hex letters, overflow, and a radix above the legal range
  task automatic test_hex_and_overflow();
    wait_block_idle();
    set_radix(rsti_pkg::RADIX_MAX);
    send_text('{rsti_pkg::CHAR_UPPER_F, rsti_pkg::CHAR_LOWER_F});
    send_text('{8'h38, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30});
    wait_block_idle();
    set_radix(5'd31);
    send_text('{rsti_pkg::CHAR_LOWER_A});
  endtask

  // radix changed between two characters of one string
  task automatic test_midstring_radix();
    wait_block_idle();
    set_radix(rsti_pkg::RADIX_MAX);
    send_char(8'h31, 1'b0);
    wait_block_idle();
    set_radix(5'd1);
    send_char(8'h31, 1'b1);
  endtask

  // long receiver hold while characters keep coming
  task automatic test_result_backpressure();
    wait_block_idle();
    set_radix(rsti_pkg::RADIX_RESET);
    tx_idle_on   = 1'b0;
    rx_long_hold = 80;
    repeat (20) send_random_string();
    tx_idle_on = 1'b1;
  endtask

  // random strings in phases of different radix and idling
  task automatic test_random_strings();
    logic [4:0] radix_plan[$] = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd7, 5'd8,
                                  5'd10, 5'd16, 5'd17, 5'd31};
    int phase, start;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_block_idle();
      set_radix(phase < radix_plan.size() ? radix_plan[phase]
                                          : 5'($urandom_range(0, 31)));
      tx_idle_on = (phase % 4 != 3);
      rx_idle_on = (phase % 5 != 4);
      start = items_sent;
      while (items_sent - start < 100 && items_sent < ITEM_TARGET)
        send_random_string();
      phase++;
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // stimulus sequence
  initial begin
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_valid         = 1'b0;
    in_char_code     = '0;
    in_end_of_string = 1'b0;
    radix_shadow     = rsti_pkg::RADIX_RESET;
    clear_parse_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_sign_and_bad_chars();
    test_hex_and_overflow();
    test_midstring_radix();
    test_result_backpressure();
    test_random_strings();

    wait_block_idle();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // result receiver: random hold per result, one long hold on request
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      if (rx_long_hold > 0) begin
        hold = rx_long_hold;
        rx_long_hold = 0;
      end else begin
        hold = rx_idle_on ? $urandom_range(0, 7) : 0;
      end
      if (hold > 0) begin
        @(negedge clk);
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
        out_stall = 1'b0;
      end
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    parse_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result value %h bad %b ovf %b", $time,
                 out_value, out_bad_digit, out_overflow);
      end else begin
        want = expected_results.pop_front();
        if (out_value !== want.value) begin
          mismatch_count++;
          $display("%0t: value expected %h actual %h", $time, want.value, out_value);
        end
        if (out_bad_digit !== want.bad_digit) begin
          mismatch_count++;
          $display("%0t: bad_digit expected %b actual %b", $time, want.bad_digit,
                   out_bad_digit);
        end
        if (out_overflow !== want.overflow) begin
          mismatch_count++;
          $display("%0t: overflow expected %b actual %b", $time, want.overflow,
                   out_overflow);
        end
      end
    end
  end

  // watchdog
  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
